FILE: sv/ir_record_stream_parser_core_assert.svh
// ----------------------------------------------------------------------------
// ir record stream parser assertion macros
// shared property wrappers for the parser core checks
// ----------------------------------------------------------------------------
`ifndef IR_RECORD_STREAM_PARSER_CORE_ASSERT_SVH
`define IR_RECORD_STREAM_PARSER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define IRSP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define IRSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// condition that must hold on the cycle after reset
`define IRSP_ASSERT_AFTER_RESET(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/irsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irsp_pkg
// types and constants shared by the ir record stream parser core
// ----------------------------------------------------------------------------
package irsp_pkg;

   localparam int TOK_DEPTH = 2;
   localparam int TOK_PTR_W = $clog2(TOK_DEPTH);
   localparam int TOK_CNT_W = $clog2(TOK_DEPTH + 1);
   localparam int RSP_DEPTH = 2;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [2:0]  FIELD_LAST     = 3'd7;
   localparam logic [2:0]  CONN_LAST      = 3'd3;
   localparam logic [3:0]  AOP_LIMIT      = 4'd8;
   localparam logic [7:0]  INDEX_MAX_BYTE = 8'hFF;
   localparam logic [15:0] INDEX_WIDE     = 16'hFFFF;

   localparam logic [7:0] OPC_CREATE  = 8'd0;
   localparam logic [7:0] OPC_CONNECT = 8'd1;

   localparam logic [3:0] KIND_HDR_NS_CHAR   = 4'd0;
   localparam logic [3:0] KIND_HDR_NAME_CHAR = 4'd1;
   localparam logic [3:0] KIND_HDR_ID        = 4'd2;
   localparam logic [3:0] KIND_CHD_NS_CHAR   = 4'd3;
   localparam logic [3:0] KIND_CHD_NAME_CHAR = 4'd4;
   localparam logic [3:0] KIND_CHD_ID        = 4'd5;
   localparam logic [3:0] KIND_COORDS        = 4'd6;
   localparam logic [3:0] KIND_CONNECTION    = 4'd7;
   localparam logic [3:0] KIND_ERROR         = 4'd8;

   localparam logic [7:0] ERR_NS_TRUNC     = 8'd0;
   localparam logic [7:0] ERR_NAME_TRUNC   = 8'd1;
   localparam logic [7:0] ERR_TIME_TRUNC   = 8'd2;
   localparam logic [7:0] ERR_CREATE_SHORT = 8'd3;
   localparam logic [7:0] ERR_COORD_TRUNC  = 8'd4;
   localparam logic [7:0] ERR_CONN_TRUNC   = 8'd5;
   localparam logic [7:0] ERR_BAD_OPCODE   = 8'd6;

   typedef enum logic [3:0] {
      PH_H_NS   = 4'd0,
      PH_H_NAME = 4'd1,
      PH_H_TIME = 4'd2,
      PH_OPCODE = 4'd3,
      PH_C_NS   = 4'd4,
      PH_C_NAME = 4'd5,
      PH_C_TIME = 4'd6,
      PH_COORDS = 4'd7,
      PH_CONN   = 4'd8
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
      logic       is_zero;
      logic       is_one;
   } tok_type;

   typedef struct packed {
      logic [3:0]         kind;
      logic [7:0]         byte_value;
      logic [63:0]        creation_seconds;
      logic signed [15:0] left_edge;
      logic signed [15:0] right_edge;
      logic signed [15:0] top_edge;
      logic signed [15:0] bottom_edge;
      logic [15:0]        source_function;
      logic [7:0]         source_argument;
      logic [15:0]        target_function;
      logic [7:0]         target_argument;
      logic               stream_done;
   } rsp_type;

endpackage

FILE: sv/ir_record_stream_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_record_stream_parser_core
// byte-serial parser for a serialized function ir stream
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle unless the output stalls, and gives at most
// one result per byte. An accepted byte is registered in the token queue,
// parsed in the back part when the result queue has room, and its result is
// queued for popping. The rate is set by the back part's parse step; a
// two-entry token queue sits between the byte front end and the parser, and a
// two-entry result queue on the output lets either side stall on its own.
// ----------------------------------------------------------------------------
module ir_record_stream_parser_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  irsp_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output irsp_pkg::rsp_type rsp_data
);
   import irsp_pkg::*;

   `include "ir_record_stream_parser_core_assert.svh"

   logic    tok_valid;
   logic    tok_pop;
   tok_type tok_data;
   logic    trunc_err;

   irsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .tok_valid (tok_valid),
      .tok_data  (tok_data),
      .tok_pop   (tok_pop)
   );

   irsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (tok_valid),
      .tok_data  (tok_data),
      .tok_pop   (tok_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // truncation error on the output beat
   assign trunc_err = !rsp_empty && (rsp_data.kind == KIND_ERROR) &&
                      (rsp_data.byte_value != ERR_BAD_OPCODE);

   `IRSP_ASSERT_NOW(a_pop_needs_token, tok_pop, tok_valid, "parser took a beat from an empty queue")
   `IRSP_ASSERT_NEXT(a_push_lands, req_push && !req_full, tok_valid, "accepted beat not queued")
   `IRSP_ASSERT_NOW(a_trunc_final, trunc_err, rsp_data.stream_done, "truncation error not final")
   `IRSP_ASSERT_AFTER_RESET(a_reset, rsp_empty && !req_full && !tok_valid, "not empty after reset")

endmodule

FILE: sv/irsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irsp_front
// accepts stream bytes, tags them and holds them in a short token queue
// ----------------------------------------------------------------------------
module irsp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  irsp_pkg::req_type req_data,
   output logic             tok_valid,
   output irsp_pkg::tok_type tok_data,
   input  logic             tok_pop
);
   import irsp_pkg::*;

   tok_type              q_ff [TOK_DEPTH];
   logic [TOK_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [TOK_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [TOK_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 push_fire;
   tok_type              tok_in;

   assign req_full  = (cnt_ff == TOK_CNT_W'(TOK_DEPTH));
   assign push_fire = req_push && !req_full;
   assign tok_valid = (cnt_ff != '0);
   assign tok_data  = q_ff[rd_ptr_ff];

   // classify the incoming beat
   always_comb begin
      tok_in.data_byte   = req_data.data_byte;
      tok_in.end_of_data = req_data.end_of_data;
      tok_in.is_zero     = (req_data.data_byte == OPC_CREATE);
      tok_in.is_one      = (req_data.data_byte == OPC_CONNECT);
   end

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + TOK_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = tok_pop ? rd_ptr_ff + TOK_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + TOK_CNT_W'(push_fire) - TOK_CNT_W'(tok_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         q_ff[wr_ptr_ff] <= tok_in;
      end
   end

endmodule

FILE: sv/irsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irsp_back
// runs the record parser on tagged bytes and queues the results
// ----------------------------------------------------------------------------
module irsp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              tok_valid,
   input  irsp_pkg::tok_type tok_data,
   output logic              tok_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output irsp_pkg::rsp_type rsp_data
);
   import irsp_pkg::*;

   phase_type   phase_ff, phase_in, cur_phase, step_phase;
   logic [2:0]  fcnt_ff, fcnt_in;
   logic [3:0]  aop_ff, aop_in, aop_step;
   logic [63:0] time_ff, time_in, time_shifted;
   logic [63:0] coord_ff, coord_in, coord_shifted;
   logic [23:0] conn_ff, conn_in, conn_shifted;
   logic        err_ff, err_in;
   logic        fire, active, is_end;
   logic        res_valid;
   rsp_type     res;

   rsp_type              q_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 push_fire, pop_fire;

   function automatic logic [15:0] widen_index(input logic [7:0] b);
      return (b == INDEX_MAX_BYTE) ? INDEX_WIDE : {8'h00, b};
   endfunction

   assign fire    = tok_valid && ((cnt_ff < RSP_CNT_W'(RSP_DEPTH)) || rsp_pop);
   assign tok_pop = fire;
   assign active  = fire && !err_ff;
   assign is_end  = tok_data.end_of_data;

   assign time_shifted  = {time_ff[55:0], tok_data.data_byte};
   assign coord_shifted = {coord_ff[55:0], tok_data.data_byte};
   assign conn_shifted  = {conn_ff[15:0], tok_data.data_byte};

   // next state
   always_comb begin
      cur_phase = phase_ff;
      if (!(phase_ff inside {[PH_H_NS:PH_CONN]})) begin
         cur_phase = PH_H_NS;
      end
      step_phase = cur_phase;
      case (cur_phase)
         PH_H_NS:   if (tok_data.is_zero) step_phase = PH_H_NAME;
         PH_H_NAME: if (tok_data.is_zero) step_phase = PH_H_TIME;
         PH_C_NS:   if (tok_data.is_zero) step_phase = PH_C_NAME;
         PH_C_NAME: if (tok_data.is_zero) step_phase = PH_C_TIME;
         PH_H_TIME: if (fcnt_ff == FIELD_LAST) step_phase = PH_OPCODE;
         PH_C_TIME: if (fcnt_ff == FIELD_LAST) step_phase = PH_COORDS;
         PH_OPCODE: begin
            if (tok_data.is_zero) begin
               step_phase = PH_C_NS;
            end else if (tok_data.is_one) begin
               step_phase = PH_CONN;
            end
         end
         PH_COORDS: if (fcnt_ff == FIELD_LAST) step_phase = PH_OPCODE;
         PH_CONN:   if (fcnt_ff >= CONN_LAST) step_phase = PH_OPCODE;
         default:   step_phase = PH_H_NS;
      endcase
      phase_in = phase_ff;
      if (fire) begin
         if (is_end) begin
            phase_in = PH_H_NS;
         end else if (!err_ff) begin
            phase_in = step_phase;
         end
      end
   end

   // byte count since the opcode, saturating
   always_comb begin
      if (cur_phase == PH_OPCODE) begin
         aop_step = '0;
      end else if (cur_phase inside {[PH_C_NS:PH_CONN]} && aop_ff < AOP_LIMIT) begin
         aop_step = aop_ff + 4'd1;
      end else begin
         aop_step = aop_ff;
      end
   end

   // field assembly
   always_comb begin
      fcnt_in  = fcnt_ff;
      aop_in   = aop_ff;
      time_in  = time_ff;
      coord_in = coord_ff;
      conn_in  = conn_ff;
      err_in   = err_ff;
      if (active) begin
         aop_in = aop_step;
         case (cur_phase)
            PH_H_NS, PH_H_NAME, PH_C_NS, PH_C_NAME: begin
               if (tok_data.is_zero) begin
                  fcnt_in = '0;
                  time_in = '0;
               end
            end
            PH_H_TIME, PH_C_TIME: begin
               time_in = time_shifted;
               if (fcnt_ff == FIELD_LAST) begin
                  fcnt_in  = '0;
                  coord_in = '0;
               end else begin
                  fcnt_in = fcnt_ff + 3'd1;
               end
            end
            PH_OPCODE: begin
               fcnt_in = '0;
               if (tok_data.is_one) begin
                  conn_in = '0;
               end else if (!tok_data.is_zero) begin
                  err_in = 1'b1;
               end
            end
            PH_COORDS: begin
               coord_in = coord_shifted;
               fcnt_in  = (fcnt_ff == FIELD_LAST) ? 3'd0 : fcnt_ff + 3'd1;
            end
            PH_CONN: begin
               if (fcnt_ff >= CONN_LAST) begin
                  fcnt_in = '0;
               end else begin
                  conn_in = conn_shifted;
                  fcnt_in = fcnt_ff + 3'd1;
               end
            end
            default: fcnt_in = fcnt_ff;
         endcase
      end
      if (fire && is_end) begin
         fcnt_in  = '0;
         aop_in   = '0;
         time_in  = '0;
         coord_in = '0;
         conn_in  = '0;
         err_in   = 1'b0;
      end
   end

   // result
   always_comb begin
      res       = '0;
      res_valid = 1'b0;
      if (active) begin
         case (cur_phase)
            PH_H_NS, PH_H_NAME, PH_C_NS, PH_C_NAME: begin
               if (!tok_data.is_zero) begin
                  case (cur_phase)
                     PH_H_NS:   res.kind = KIND_HDR_NS_CHAR;
                     PH_H_NAME: res.kind = KIND_HDR_NAME_CHAR;
                     PH_C_NS:   res.kind = KIND_CHD_NS_CHAR;
                     default:   res.kind = KIND_CHD_NAME_CHAR;
                  endcase
                  res.byte_value = tok_data.data_byte;
                  res_valid      = 1'b1;
               end
            end
            PH_H_TIME, PH_C_TIME: begin
               if (fcnt_ff == FIELD_LAST) begin
                  res.kind             = (cur_phase == PH_C_TIME) ? KIND_CHD_ID : KIND_HDR_ID;
                  res.creation_seconds = time_shifted;
                  res_valid            = 1'b1;
               end
            end
            PH_OPCODE: begin
               if (!tok_data.is_zero && !tok_data.is_one) begin
                  res.kind       = KIND_ERROR;
                  res.byte_value = ERR_BAD_OPCODE;
                  res_valid      = 1'b1;
               end
            end
            PH_COORDS: begin
               if (fcnt_ff == FIELD_LAST) begin
                  res.kind        = KIND_COORDS;
                  res.left_edge   = coord_shifted[63:48];
                  res.right_edge  = coord_shifted[47:32];
                  res.top_edge    = coord_shifted[31:16];
                  res.bottom_edge = coord_shifted[15:0];
                  res_valid       = 1'b1;
               end
            end
            PH_CONN: begin
               if (fcnt_ff >= CONN_LAST) begin
                  res.kind            = KIND_CONNECTION;
                  res.source_function = widen_index(conn_ff[23:16]);
                  res.source_argument = conn_ff[15:8];
                  res.target_function = widen_index(conn_ff[7:0]);
                  res.target_argument = tok_data.data_byte;
                  res_valid           = 1'b1;
               end
            end
            default: res_valid = 1'b0;
         endcase
         if (is_end) begin
            // truncated field replaces whatever this beat gave
            if (step_phase != PH_OPCODE) begin
               res       = '0;
               res.kind  = KIND_ERROR;
               res_valid = 1'b1;
               if (step_phase inside {[PH_C_NS:PH_C_TIME]} && aop_step < AOP_LIMIT) begin
                  res.byte_value = ERR_CREATE_SHORT;
               end else begin
                  case (step_phase)
                     PH_H_NS, PH_C_NS:     res.byte_value = ERR_NS_TRUNC;
                     PH_H_NAME, PH_C_NAME: res.byte_value = ERR_NAME_TRUNC;
                     PH_H_TIME, PH_C_TIME: res.byte_value = ERR_TIME_TRUNC;
                     PH_COORDS:            res.byte_value = ERR_COORD_TRUNC;
                     default:              res.byte_value = ERR_CONN_TRUNC;
                  endcase
               end
            end
            res.stream_done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_H_NS;
         fcnt_ff  <= '0;
         aop_ff   <= '0;
         time_ff  <= '0;
         coord_ff <= '0;
         conn_ff  <= '0;
         err_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         fcnt_ff  <= fcnt_in;
         aop_ff   <= aop_in;
         time_ff  <= time_in;
         coord_ff <= coord_in;
         conn_ff  <= conn_in;
         err_ff   <= err_in;
      end
   end

   // result queue
   assign push_fire = fire && res_valid;
   assign pop_fire  = rsp_pop && !rsp_empty;
   assign rsp_empty = (cnt_ff == '0);
   assign rsp_data  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + RSP_CNT_W'(push_fire) - RSP_CNT_W'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         q_ff[wr_ptr_ff] <= res;
      end
   end

endmodule
